FILE: src/cete_pkg.sv
// Shared types and codes for the constant expression token evaluator.
// No dependencies.
package cete_pkg;

  localparam int unsigned CmdW = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned ShW = 5;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    CMD_INT = 3'd0,
    CMD_SHL = 3'd1,
    CMD_SHR = 3'd2,
    CMD_MUL = 3'd3,
    CMD_DIV = 3'd4,
    CMD_ADD = 3'd5,
    CMD_SUB = 3'd6,
    CMD_END = 3'd7
  } cmd_t;

  // Pending operator at one precedence level
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_ONE  = 2'd1,
    PEND_TWO  = 2'd2
  } pend_t;

  // Classified token passed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [DataW-1:0]  value;
  } tok_t;

endpackage

FILE: src/cete_front.sv
// Front end: accepts token beats and holds them in a short queue.
// Depends on cete_pkg.
module cete_front #(
  parameter int unsigned Depth = cete_pkg::QueueDepth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cete_pkg::CmdW-1:0]         command,
  input  logic signed [cete_pkg::DataW-1:0] token_value,
  output logic                              q_valid,
  input  logic                              q_ready,
  output cete_pkg::tok_t                    q_tok
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cete_pkg::tok_t   mem [Depth];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  assign in_ready = (count != (AW+1)'(Depth));
  assign q_valid  = (count != '0);
  assign q_tok    = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Store accepted beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{cmd: cete_pkg::cmd_t'(command), value: token_value};
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

FILE: src/cete_div.sv
// Serial signed 32-bit divider, one quotient bit per cycle.
// Depends on cete_pkg.
module cete_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cete_pkg::DataW-1:0]   dividend,
  input  logic [cete_pkg::DataW-1:0]   divisor,
  output logic                         done,
  output logic [cete_pkg::DataW-1:0]   quotient
);
  localparam int unsigned W = cete_pkg::DataW;

  logic          busy;
  logic [5:0]    cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dsr;
  logic          neg;

  assign quotient = neg ? (W'(0) - quo) : quo;

  // Restoring division on magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(W);
        rem  <= '0;
        quo  <= dividend[W-1] ? W'(0) - dividend : dividend;
        dsr  <= divisor[W-1] ? W'(0) - divisor : divisor;
        neg  <= dividend[W-1] ^ divisor[W-1];
      end else if (busy) begin
        if ({1'b0, rem, quo[W-1]} >= {2'b0, dsr}) begin
          rem <= W'({rem, quo[W-1]} - {1'b0, dsr});
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], quo[W-1]};
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: src/cete_back.sv
// Back end: folds tokens through the three precedence levels.
// Depends on cete_pkg and cete_div.
module cete_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  cete_pkg::tok_t                    q_tok,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cete_pkg::DataW-1:0] result_value,
  output logic                              divide_by_zero,
  output logic                              token_taken
);
  localparam int unsigned W = cete_pkg::DataW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PROD  = 5'b00010,
    S_DIVW  = 5'b00100,
    S_SUM   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t            state;
  cete_pkg::tok_t    tok;
  logic [W-1:0]      sum_acc, prod_acc, shift_acc;
  cete_pkg::pend_t   sum_pend, prod_pend, shift_pend;
  logic              expect_op, zdiv;
  logic [W-1:0]      mul_r;
  logic              div_start, div_done;
  logic [W-1:0]      div_q;
  logic [W-1:0]      opnd;
  logic [W-1:0]      shifted;
  logic              emit_go;

  assign q_ready = (state == S_IDLE);
  assign emit_go = (state == S_EMIT) && (!out_valid || out_ready);

  // Apply pending shift to operand
  always_comb begin
    case (shift_pend)
      cete_pkg::PEND_ONE: shifted = shift_acc << opnd[cete_pkg::ShW-1:0];
      cete_pkg::PEND_TWO: shifted = W'($signed(shift_acc) >>> opnd[cete_pkg::ShW-1:0]);
      default:            shifted = opnd;
    endcase
  end

  assign div_start = (state == S_PROD) && (prod_pend == cete_pkg::PEND_TWO)
                     && (shift_acc != '0);

  cete_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(prod_acc), .divisor(shift_acc),
    .done(div_done), .quotient(div_q)
  );

  // Operand held for the shift stage: zero when missing
  always_comb begin
    opnd = (q_tok.cmd == cete_pkg::CMD_INT) ? q_tok.value : '0;
  end

  always_ff @(posedge clk) begin
    mul_r <= prod_acc * shift_acc;
  end

  // Sequence one token
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sum_acc    <= '0; prod_acc <= '0; shift_acc <= '0;
      sum_pend   <= cete_pkg::PEND_NONE;
      prod_pend  <= cete_pkg::PEND_NONE;
      shift_pend <= cete_pkg::PEND_NONE;
      expect_op  <= 1'b1;
      zdiv       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Hold the result beat until taken
      if (emit_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (q_valid && q_ready) begin
          tok <= q_tok;
          if (expect_op) begin
            shift_acc <= shifted;
          end
          if (expect_op && q_tok.cmd == cete_pkg::CMD_INT) begin
            shift_pend <= cete_pkg::PEND_NONE;
            expect_op  <= 1'b0;
          end else if (q_tok.cmd == cete_pkg::CMD_SHL ||
                       q_tok.cmd == cete_pkg::CMD_SHR) begin
            shift_pend <= (q_tok.cmd == cete_pkg::CMD_SHL) ?
                          cete_pkg::PEND_ONE : cete_pkg::PEND_TWO;
            expect_op  <= 1'b1;
          end else begin
            shift_pend <= cete_pkg::PEND_NONE;
            expect_op  <= 1'b0;
            state      <= S_PROD;
          end
        end
        // Fold shift level into product (multiply result lands next cycle)
        S_PROD: begin
          if (prod_pend == cete_pkg::PEND_TWO) begin
            if (shift_acc == '0) begin
              prod_acc <= '0;
              zdiv     <= 1'b1;
              prod_pend <= cete_pkg::PEND_NONE;
              state    <= S_SUM;
            end else state <= S_DIVW;
          end else if (prod_pend == cete_pkg::PEND_ONE) begin
            prod_pend <= cete_pkg::PEND_NONE;
            state     <= S_DIVW;
          end else begin
            prod_acc <= shift_acc;
            state    <= S_SUM;
          end
        end
        S_DIVW: begin
          if (prod_pend == cete_pkg::PEND_NONE) begin
            prod_acc <= mul_r;
            state    <= S_SUM;
          end else if (div_done) begin
            prod_acc  <= div_q;
            prod_pend <= cete_pkg::PEND_NONE;
            state     <= S_SUM;
          end
        end
        // Dispatch on operator level
        S_SUM: begin
          if (tok.cmd == cete_pkg::CMD_MUL || tok.cmd == cete_pkg::CMD_DIV) begin
            prod_pend <= (tok.cmd == cete_pkg::CMD_MUL) ?
                         cete_pkg::PEND_ONE : cete_pkg::PEND_TWO;
            expect_op <= 1'b1;
            state     <= S_IDLE;
          end else begin
            case (sum_pend)
              cete_pkg::PEND_ONE: sum_acc <= sum_acc + prod_acc;
              cete_pkg::PEND_TWO: sum_acc <= sum_acc - prod_acc;
              default:            sum_acc <= prod_acc;
            endcase
            if (tok.cmd == cete_pkg::CMD_ADD || tok.cmd == cete_pkg::CMD_SUB) begin
              sum_pend  <= (tok.cmd == cete_pkg::CMD_ADD) ?
                           cete_pkg::PEND_ONE : cete_pkg::PEND_TWO;
              expect_op <= 1'b1;
              state     <= S_IDLE;
            end else begin
              sum_pend <= cete_pkg::PEND_NONE;
              state    <= S_EMIT;
            end
          end
        end
        // Emit result once the output register is free, clear, absorb a finishing integer
        S_EMIT: if (emit_go) begin
          result_value   <= sum_acc;
          divide_by_zero <= zdiv;
          token_taken    <= (tok.cmd == cete_pkg::CMD_END);
          sum_acc <= '0; prod_acc <= '0;
          prod_pend <= cete_pkg::PEND_NONE;
          shift_pend <= cete_pkg::PEND_NONE;
          zdiv <= 1'b0;
          if (tok.cmd == cete_pkg::CMD_INT) begin
            shift_acc <= tok.value;
            expect_op <= 1'b0;
          end else begin
            shift_acc <= '0;
            expect_op <= 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/const_expr_token_evaluator_unit.sv
// Top level of the constant expression token evaluator.
// Depends on cete_pkg, cete_front, cete_back.
//
// Takes integer and operator tokens and returns one result beat per finished
// expression. A queue of QDepth tokens sits in front of the evaluator. An
// operand or shift operator is handled in the idle state; any other token
// passes the product and sum states, waiting when it folds a pending multiply
// or nonzero divide, one quotient bit per cycle; a finishing token also emits.
// A result beat waits in its output register until taken while the evaluator
// carries on; it stalls only when a second result is ready before the first goes.
module const_expr_token_evaluator_unit #(
  parameter int unsigned QDepth = cete_pkg::QueueDepth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cete_pkg::CmdW-1:0]         command,
  input  logic signed [cete_pkg::DataW-1:0] token_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cete_pkg::DataW-1:0] result_value,
  output logic                              divide_by_zero,
  output logic                              token_taken
);
  logic           q_valid;
  logic           q_ready;
  cete_pkg::tok_t q_tok;

  cete_front #(.Depth(QDepth)) u_front (
    .clk, .rst, .in_valid, .in_ready, .command, .token_value,
    .q_valid, .q_ready, .q_tok
  );

  cete_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_tok,
    .out_valid, .out_ready, .result_value, .divide_by_zero, .token_taken
  );
endmodule

FILE: verif/cete_checker.sv
// Checker for the constant expression token evaluator: watches both channels,
// predicts each result from the accepted tokens and compares. Depends on cete_pkg.
module cete_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [cete_pkg::CmdW-1:0]         command,
  input  logic signed [cete_pkg::DataW-1:0] token_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [cete_pkg::DataW-1:0] result_value,
  input  logic                              divide_by_zero,
  input  logic                              token_taken,
  output int                                fail_count,
  output int                                pending_count
);
  typedef struct packed {
    logic [cete_pkg::DataW-1:0] value;
    logic                       dbz;
    logic                       taken;
  } expr_result_t;

  expr_result_t result_q[$];

  logic [cete_pkg::DataW-1:0] sum_acc, prod_acc, shift_acc;
  cete_pkg::pend_t            sum_op, prod_op, shift_op;
  logic                       want_operand, dbz_seen;

  assign pending_count = result_q.size();

  function automatic logic [cete_pkg::DataW-1:0] sdiv(
    input logic [cete_pkg::DataW-1:0] a,
    input logic [cete_pkg::DataW-1:0] b);
    logic [cete_pkg::DataW-1:0] ma, mb, q;
    ma = a[cete_pkg::DataW-1] ? -a : a;
    mb = b[cete_pkg::DataW-1] ? -b : b;
    q = ma / mb;
    return ((a ^ b) & 32'h8000_0000) != 0 ? -q : q;
  endfunction

  task automatic clear_expr();
    sum_acc = '0; prod_acc = '0; shift_acc = '0;
    sum_op = cete_pkg::PEND_NONE; prod_op = cete_pkg::PEND_NONE;
    shift_op = cete_pkg::PEND_NONE;
    want_operand = 1'b1; dbz_seen = 1'b0;
  endtask

  task automatic absorb_operand(input logic [cete_pkg::DataW-1:0] x);
    case (shift_op)
      cete_pkg::PEND_ONE: shift_acc = shift_acc << x[cete_pkg::ShW-1:0];
      cete_pkg::PEND_TWO:
        shift_acc = $unsigned($signed(shift_acc) >>> x[cete_pkg::ShW-1:0]);
      default:  shift_acc = x;
    endcase
    shift_op = cete_pkg::PEND_NONE;
    want_operand = 1'b0;
  endtask

  task automatic fold_shift();
    case (prod_op)
      cete_pkg::PEND_ONE: prod_acc = prod_acc * shift_acc;
      cete_pkg::PEND_TWO: begin
        if (shift_acc == '0) begin
          dbz_seen = 1'b1;
          prod_acc = '0;
        end else begin
          prod_acc = sdiv(prod_acc, shift_acc);
        end
      end
      default: prod_acc = shift_acc;
    endcase
    prod_op = cete_pkg::PEND_NONE;
  endtask

  task automatic fold_product();
    case (sum_op)
      cete_pkg::PEND_ONE: sum_acc = sum_acc + prod_acc;
      cete_pkg::PEND_TWO: sum_acc = sum_acc - prod_acc;
      default:  sum_acc = prod_acc;
    endcase
    sum_op = cete_pkg::PEND_NONE;
  endtask

  // Advance the predicted evaluator by one token
  task automatic predict_token(input cete_pkg::cmd_t c,
                               input logic [cete_pkg::DataW-1:0] v);
    expr_result_t r;
    if (want_operand) begin
      if (c == cete_pkg::CMD_INT) begin
        absorb_operand(v);
        return;
      end
      absorb_operand('0);
    end
    case (c)
      cete_pkg::CMD_SHL: begin shift_op = cete_pkg::PEND_ONE; want_operand = 1'b1; end
      cete_pkg::CMD_SHR: begin shift_op = cete_pkg::PEND_TWO; want_operand = 1'b1; end
      cete_pkg::CMD_MUL, cete_pkg::CMD_DIV: begin
        fold_shift();
        prod_op = (c == cete_pkg::CMD_MUL) ? cete_pkg::PEND_ONE : cete_pkg::PEND_TWO;
        want_operand = 1'b1;
      end
      cete_pkg::CMD_ADD, cete_pkg::CMD_SUB: begin
        fold_shift();
        fold_product();
        sum_op = (c == cete_pkg::CMD_ADD) ? cete_pkg::PEND_ONE : cete_pkg::PEND_TWO;
        want_operand = 1'b1;
      end
      default: begin
        fold_shift();
        fold_product();
        r.value = sum_acc;
        r.dbz = dbz_seen;
        r.taken = (c == cete_pkg::CMD_END);
        result_q.push_back(r);
        clear_expr();
        if (c == cete_pkg::CMD_INT) absorb_operand(v);
      end
    endcase
  endtask

  initial clear_expr();
  initial fail_count = 0;

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    expr_result_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected: %0d", result_value);
          fail_count++;
        end else begin
          e = result_q.pop_front();
          if (e.value !== result_value) begin
            $error("result_value exp %0d got %0d", $signed(e.value), result_value);
            fail_count++;
          end
          if (e.dbz !== divide_by_zero) begin
            $error("divide_by_zero exp %0b got %0b", e.dbz, divide_by_zero);
            fail_count++;
          end
          if (e.taken !== token_taken) begin
            $error("token_taken exp %0b got %0b", e.taken, token_taken);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_token(cete_pkg::cmd_t'(command), token_value);
    end
  end
endmodule

FILE: verif/const_expr_token_evaluator_unit_tb.sv
// Testbench top for the constant expression token evaluator: drives tokens,
// stalls the result side and gives the verdict. Depends on cete_pkg, cete_checker.
module const_expr_token_evaluator_unit_tb;
  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [cete_pkg::CmdW-1:0]          command = cete_pkg::CMD_END;
  logic signed [cete_pkg::DataW-1:0]  token_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [cete_pkg::DataW-1:0]  result_value;
  logic                               divide_by_zero;
  logic                               token_taken;
  int                                 fail_count, pending_count;
  int                                 idle_pct = 10;
  logic                               hold_req = 1'b0;
  logic                               hold_off = 1'b0;

  always #2 clk = ~clk;

  const_expr_token_evaluator_unit u_top (
    .clk, .rst, .in_valid, .in_ready, .command, .token_value,
    .out_valid, .out_ready, .result_value, .divide_by_zero, .token_taken
  );

  cete_checker u_chk (
    .clk, .rst, .in_valid, .in_ready, .command, .token_value,
    .out_valid, .out_ready, .result_value, .divide_by_zero, .token_taken,
    .fail_count, .pending_count
  );

  // Random stall on the result side, overridden by the long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
  end

  // Offer one token and hold it until the beat is taken; valid stays high
  // afterwards unless the next call idles or the caller drops it
  task automatic send_token(input cete_pkg::cmd_t c,
                            input logic [cete_pkg::DataW-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= c;
    token_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [cete_pkg::DataW-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(3)) - 32'd1;
      3: return 32'($urandom_range(40));
      default: return $urandom();
    endcase
  endfunction

  function automatic cete_pkg::cmd_t rand_op();
    return cete_pkg::cmd_t'($urandom_range(cete_pkg::CMD_SHL, cete_pkg::CMD_SUB));
  endfunction

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty expression, missing operands, extremes, every operator
    send_token(cete_pkg::CMD_END, '0);
    send_token(cete_pkg::CMD_ADD, '0); send_token(cete_pkg::CMD_END, '0);
    send_token(cete_pkg::CMD_INT, 32'h8000_0000); send_token(cete_pkg::CMD_DIV, '0);
    send_token(cete_pkg::CMD_INT, 32'hffff_ffff); send_token(cete_pkg::CMD_END, '0);
    send_token(cete_pkg::CMD_INT, 32'd7); send_token(cete_pkg::CMD_DIV, '0);
    send_token(cete_pkg::CMD_INT, 32'd0); send_token(cete_pkg::CMD_SUB, '0);
    send_token(cete_pkg::CMD_INT, 32'hffff_fff9); send_token(cete_pkg::CMD_DIV, '0);
    send_token(cete_pkg::CMD_INT, 32'd2);
    send_token(cete_pkg::CMD_INT, 32'h7fff_ffff);
    send_token(cete_pkg::CMD_MUL, '0); send_token(cete_pkg::CMD_INT, 32'h7fff_ffff);
    send_token(cete_pkg::CMD_ADD, '0); send_token(cete_pkg::CMD_INT, 32'hffff_ff00);
    send_token(cete_pkg::CMD_SHR, '0); send_token(cete_pkg::CMD_INT, 32'd36);
    send_token(cete_pkg::CMD_SHL, '0); send_token(cete_pkg::CMD_INT, 32'hffff_ffff);
    send_token(cete_pkg::CMD_END, '0);
    in_valid <= 1'b0;

    // Sender pause until everything has drained
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    // Random: mostly well-formed expressions, some noise
    n = 0;
    while (n < 550) begin
      if (n > 200 && n < 320) idle_pct = 0;
      else idle_pct = 10;
      if (n >= 400) hold_req = 1'b1;
      if ($urandom_range(9) == 0) begin
        send_token(cete_pkg::cmd_t'($urandom_range(7)), $urandom());
        n++;
      end else begin
        int len;
        len = $urandom_range(1, 4);
        send_token(cete_pkg::CMD_INT, rand_value()); n++;
        repeat (len) begin
          send_token(rand_op(), $urandom()); n++;
          send_token(cete_pkg::CMD_INT, rand_value()); n++;
        end
        if ($urandom_range(3) != 0) begin
          send_token(cete_pkg::CMD_END, $urandom()); n++;
        end
      end
    end
    send_token(cete_pkg::CMD_END, '0);
    in_valid <= 1'b0;

    // Drain, then settle
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Long receiver hold-off, counted in cycles
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
